// ===== src/egnms_pkg.sv =====
// ----------------------------------------------------------------------------
// egnms_pkg
// Shared types, codes and defaults for the edge gradient and suppression block.
// ----------------------------------------------------------------------------
package egnms_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  // Direction codes
  localparam logic [2:0] DIR_0    = 3'd0;
  localparam logic [2:0] DIR_45   = 3'd1;
  localparam logic [2:0] DIR_90   = 3'd2;
  localparam logic [2:0] DIR_135  = 3'd3;
  localparam logic [2:0] DIR_NONE = 3'd4;

  // Q8 tangents of 22.5 and 67.5 degrees
  localparam logic [9:0] TAN_LO_Q8 = 10'd106;
  localparam logic [9:0] TAN_HI_Q8 = 10'd618;

  localparam int SQ_W   = 18;
  localparam int MAG_W  = 13;
  localparam int ROOT_X = 26;

  typedef struct packed {
    logic [7:0] pixel;
    logic       drain;
  } in_t;

  typedef struct packed {
    logic [MAG_W-1:0] edge_magnitude;
    logic [2:0]       direction;
    logic             last_pixel;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX,
    ST_EMIT,
    ST_RDS,
    ST_RDN1,
    ST_RDN2,
    ST_SQ_INIT,
    ST_ROOT,
    ST_OUT
  } state_t;

endpackage

// ===== src/egnms_ram.sv =====
// ----------------------------------------------------------------------------
// egnms_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module egnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/edge_gradient_nonmax_suppress_top.sv =====
// ----------------------------------------------------------------------------
// edge_gradient_nonmax_suppress_top
// Gradient, direction quantisation, non-maximum suppression and magnitude root.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one request at a time; each result lags its
// pixel by one row and one column, and drain requests push out the last ones.
// A drain during the image yields nothing and the block stays idle. A result
// skips the square root when the pixel is suppressed, and it waits on
// out_stall. The single read port of the squared-magnitude row RAM is
// visited up to three times per pixel, and the bit-per-cycle square root
// takes 13 steps and a rounding step. No request is taken while a result
// is pending. The row RAMs need no clearing.
module edge_gradient_nonmax_suppress_top #(
  parameter int MAX_WIDTH  = egnms_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = egnms_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  egnms_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output egnms_pkg::out_t                  out_data,
  input  logic                             cfg_we,
  input  logic [egnms_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [egnms_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int MAW = $clog2(3 * MAX_WIDTH);
  localparam int DAW = $clog2(2 * MAX_WIDTH);
  localparam int SQ  = egnms_pkg::SQ_W;
  localparam int MW  = egnms_pkg::MAG_W;
  localparam int XW  = egnms_pkg::ROOT_X;

  egnms_pkg::state_t state_r, state_nxt;

  logic [egnms_pkg::CFG_W-1:0] width_r, height_r;
  logic [RW-1:0]  row_r, row_nxt, oi_r, oi_nxt;
  logic [CW-1:0]  col_r, col_nxt, oj_r, oj_nxt;
  logic [1:0]     rm3_r, rm3_nxt;
  logic [7:0]     left_r, left_nxt, pix_r, pix_nxt;
  logic [SQ-1:0]  s_r, s_nxt;
  logic [2:0]     d_r, d_nxt;
  logic           supp_r, supp_nxt;
  logic [MAW-1:0] n2a_r, n2a_nxt;
  logic [XW-1:0]  x_r, x_nxt;
  logic [15:0]    rem_r, rem_nxt;
  logic [MW-1:0]  root_r, root_nxt;
  logic [3:0]     step_r, step_nxt;
  egnms_pkg::out_t out_r, out_nxt;

  // RAM ports
  logic           pix_we, mag_we, dir_we;
  logic [CW-1:0]  pix_wa, pix_ra;
  logic [7:0]     pix_rd;
  logic [MAW-1:0] mag_wa, mag_ra;
  logic [SQ-1:0]  mag_wd, mag_rd;
  logic [DAW-1:0] dir_wa, dir_ra;
  logic [2:0]     dir_wd, dir_rd;

  // Effective geometry, clamped
  logic [EW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    if (width_r < 11'd3) eff_w = EW'(3);
    else if (32'(width_r) > 32'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
    else eff_w = EW'(width_r);
    if (height_r < 11'd3) eff_h = HW'(3);
    else if (32'(height_r) > 32'(MAX_HEIGHT)) eff_h = HW'(MAX_HEIGHT);
    else eff_h = HW'(height_r);
  end

  function automatic logic [MAW-1:0] mag_addr(input logic [1:0] sel, input logic [CW-1:0] col);
    logic [MAW-1:0] base;
    case (sel)
      2'd0:    base = '0;
      2'd1:    base = MAW'(MAX_WIDTH);
      default: base = MAW'(2 * MAX_WIDTH);
    endcase
    return base + MAW'(col);
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] m);
    return (m == 2'd2) ? 2'd0 : m + 2'd1;
  endfunction

  // Gradient and direction of the current pixel
  logic [7:0]       left_v, up_v, ax, ay;
  logic signed [8:0] gx, gy;
  logic [SQ-1:0]    sq_v;
  logic [17:0]      n_v, lo_v, hi_v;
  logic [2:0]       dir_v;
  logic             opp;

  always_comb begin
    left_v = (col_r == '0) ? pix_r : left_r;
    up_v   = (row_r == '0) ? pix_r : pix_rd;
    gx = $signed({1'b0, left_v}) - $signed({1'b0, pix_r});
    gy = $signed({1'b0, up_v}) - $signed({1'b0, pix_r});
    ax = gx[8] ? 8'(-gx) : gx[7:0];
    ay = gy[8] ? 8'(-gy) : gy[7:0];
    sq_v = SQ'({8'd0, ax} * {8'd0, ax}) + SQ'({8'd0, ay} * {8'd0, ay});
    n_v  = {2'b00, ax, 8'd0};
    lo_v = 18'({8'd0, ay} * {8'd0, egnms_pkg::TAN_LO_Q8});
    hi_v = 18'({8'd0, ay} * {8'd0, egnms_pkg::TAN_HI_Q8});
    opp  = (gx != '0) && ((!gx[8]) != (!gy[8] && gy != '0));
    if (ax == '0 && ay == '0) dir_v = egnms_pkg::DIR_NONE;
    else if (ay == '0) dir_v = egnms_pkg::DIR_90;
    else if (opp) begin
      if (n_v < lo_v) dir_v = egnms_pkg::DIR_0;
      else if (n_v < hi_v) dir_v = egnms_pkg::DIR_45;
      else dir_v = egnms_pkg::DIR_90;
    end else begin
      if (n_v <= lo_v) dir_v = egnms_pkg::DIR_0;
      else if (n_v <= hi_v) dir_v = egnms_pkg::DIR_135;
      else dir_v = egnms_pkg::DIR_90;
    end
  end

  // Square-root step
  logic [15:0] rem_sh, trial;
  always_comb begin
    rem_sh = {rem_r[13:0], x_r[XW-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
  end

  // Neighbour selection for suppression
  logic [1:0]    om3m, om3p;
  logic [CW-1:0] ojm, ojp;
  logic          chk;
  logic [MAW-1:0] n1a, n2a;

  always_comb begin
    om3m = inc3(inc3(rm3_r));
    om3p = inc3(rm3_r);
    ojm  = oj_r - CW'(1);
    ojp  = oj_r + CW'(1);
    chk  = (dir_rd <= egnms_pkg::DIR_135) && (oi_r >= RW'(2)) &&
           (32'(oi_r) + 32'd3 <= 32'(eff_h));
    n1a = mag_addr(om3m, oj_r);
    n2a = mag_addr(om3p, oj_r);
    unique case (dir_rd)
      egnms_pkg::DIR_0: begin
      end
      egnms_pkg::DIR_45: begin
        chk = chk && (oj_r >= CW'(1)) && (32'(oj_r) + 32'd2 <= 32'(eff_w));
        n1a = mag_addr(rm3_r, ojm);
        n2a = mag_addr(rm3_r, ojp);
      end
      egnms_pkg::DIR_90: begin
        chk = chk && (oj_r >= CW'(2)) && (32'(oj_r) + 32'd3 <= 32'(eff_w));
        n1a = mag_addr(om3m, ojp);
        n2a = mag_addr(om3p, ojm);
      end
      egnms_pkg::DIR_135: begin
        chk = chk && (oj_r >= CW'(2)) && (32'(oj_r) + 32'd3 <= 32'(eff_w));
        n1a = mag_addr(om3p, ojp);
        n2a = mag_addr(om3m, ojm);
      end
      default: chk = 1'b0;
    endcase
  end

  // Counter advance for the next position
  logic [RW-1:0] row_adv;
  logic [CW-1:0] col_adv;
  logic [1:0]    rm3_adv;
  always_comb begin
    if (32'(col_r) + 32'd1 >= 32'(eff_w)) begin
      col_adv = '0;
      row_adv = row_r + RW'(1);
      rm3_adv = inc3(rm3_r);
    end else begin
      col_adv = col_r + CW'(1);
      row_adv = row_r;
      rm3_adv = rm3_r;
    end
  end

  // Next state and datapath
  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r; col_nxt = col_r; rm3_nxt = rm3_r;
    left_nxt = left_r; pix_nxt = pix_r;
    oi_nxt = oi_r; oj_nxt = oj_r; s_nxt = s_r; d_nxt = d_r;
    supp_nxt = supp_r; n2a_nxt = n2a_r;
    x_nxt = x_r; rem_nxt = rem_r; root_nxt = root_r; step_nxt = step_r;
    out_nxt = out_r;
    pix_we = 1'b0; mag_we = 1'b0; dir_we = 1'b0;
    pix_wa = col_r; pix_ra = col_r;
    mag_wa = mag_addr(rm3_r, col_r); mag_wd = sq_v;
    dir_wa = row_r[0] ? DAW'(MAX_WIDTH) + DAW'(col_r) : DAW'(col_r);
    dir_wd = dir_v;
    mag_ra = n1a;
    dir_ra = oi_r[0] ? DAW'(MAX_WIDTH) + DAW'(oj_r) : DAW'(oj_r);
    in_stall = 1'b1;

    unique case (state_r)
      egnms_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          pix_nxt = in_data.pixel;
          if (32'(row_r) < 32'(eff_h)) begin
            if (!in_data.drain) state_nxt = egnms_pkg::ST_PIX;
          end else begin
            state_nxt = egnms_pkg::ST_EMIT;
          end
        end
      end
      egnms_pkg::ST_PIX: begin
        // Write the new gradient and pixel back to the row stores
        pix_we = 1'b1; mag_we = 1'b1; dir_we = 1'b1;
        left_nxt = pix_r;
        state_nxt = egnms_pkg::ST_EMIT;
      end
      egnms_pkg::ST_EMIT: begin
        if (row_r >= RW'(2) || (row_r == RW'(1) && col_r != '0)) begin
          if (col_r != '0) begin
            oi_nxt = row_r - RW'(1);
            oj_nxt = col_r - CW'(1);
            rm3_nxt = rm3_r;
          end else begin
            oi_nxt = row_r - RW'(2);
            oj_nxt = CW'(eff_w - EW'(1));
          end
          // Issue the centre reads; crow_m3_r takes the centre row phase
          mag_ra = mag_addr((col_r != '0) ? inc3(inc3(rm3_r)) : inc3(rm3_r), oj_nxt);
          dir_ra = oi_nxt[0] ? DAW'(MAX_WIDTH) + DAW'(oj_nxt) : DAW'(oj_nxt);
          state_nxt = egnms_pkg::ST_RDS;
        end else begin
          row_nxt = row_adv; col_nxt = col_adv; rm3_nxt = rm3_adv;
          state_nxt = egnms_pkg::ST_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  // Second half of the sequencer runs on the centre row phase
  logic [1:0] crow_m3_r;
  logic [1:0] crow_m3_nxt;
  always_comb begin
    crow_m3_nxt = crow_m3_r;
    if (state_r == egnms_pkg::ST_EMIT)
      crow_m3_nxt = (col_r != '0) ? inc3(inc3(rm3_r)) : inc3(rm3_r);
  end

  // Neighbour reads, root and delivery
  egnms_pkg::state_t state2_nxt;
  logic [SQ-1:0]  s2_nxt;
  logic [2:0]     d2_nxt;
  logic           supp2_nxt;
  logic [MAW-1:0] n2a2_nxt, mag_ra2;
  logic           use_ra2;
  logic [XW-1:0]  x2_nxt;
  logic [15:0]    rem2_nxt;
  logic [MW-1:0]  root2_nxt;
  logic [3:0]     step2_nxt;
  egnms_pkg::out_t out2_nxt;
  logic [RW-1:0]  row2_nxt;
  logic [CW-1:0]  col2_nxt;
  logic [1:0]     rm32_nxt;
  logic           use_cnt2;
  logic [MAW-1:0] cn1a, cn2a;

  // Neighbour addresses relative to the centre row phase
  always_comb begin
    cn1a = n1a; cn2a = n2a;
    unique case (dir_rd)
      egnms_pkg::DIR_0: begin
        cn1a = mag_addr(inc3(inc3(crow_m3_r)), oj_r);
        cn2a = mag_addr(inc3(crow_m3_r), oj_r);
      end
      egnms_pkg::DIR_45: begin
        cn1a = mag_addr(crow_m3_r, ojm);
        cn2a = mag_addr(crow_m3_r, ojp);
      end
      egnms_pkg::DIR_90: begin
        cn1a = mag_addr(inc3(inc3(crow_m3_r)), ojp);
        cn2a = mag_addr(inc3(crow_m3_r), ojm);
      end
      egnms_pkg::DIR_135: begin
        cn1a = mag_addr(inc3(crow_m3_r), ojp);
        cn2a = mag_addr(inc3(inc3(crow_m3_r)), ojm);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state2_nxt = state_nxt;
    s2_nxt = s_nxt; d2_nxt = d_nxt; supp2_nxt = supp_nxt; n2a2_nxt = n2a_nxt;
    x2_nxt = x_nxt; rem2_nxt = rem_nxt; root2_nxt = root_nxt; step2_nxt = step_nxt;
    out2_nxt = out_nxt;
    row2_nxt = row_nxt; col2_nxt = col_nxt; rm32_nxt = rm3_nxt;
    use_cnt2 = 1'b0;
    use_ra2 = 1'b0; mag_ra2 = cn1a;
    out_valid = 1'b0;

    unique case (state_r)
      egnms_pkg::ST_RDS: begin
        s2_nxt = mag_rd;
        d2_nxt = dir_rd;
        supp2_nxt = 1'b0;
        n2a2_nxt = cn2a;
        if (chk) begin
          use_ra2 = 1'b1; mag_ra2 = cn1a;
          state2_nxt = egnms_pkg::ST_RDN1;
        end else begin
          state2_nxt = egnms_pkg::ST_SQ_INIT;
        end
      end
      egnms_pkg::ST_RDN1: begin
        supp2_nxt = s_r < mag_rd;
        use_ra2 = 1'b1; mag_ra2 = n2a_r;
        state2_nxt = egnms_pkg::ST_RDN2;
      end
      egnms_pkg::ST_RDN2: begin
        supp2_nxt = supp_r || (s_r < mag_rd);
        state2_nxt = egnms_pkg::ST_SQ_INIT;
      end
      egnms_pkg::ST_SQ_INIT: begin
        out2_nxt.direction = d_r;
        out2_nxt.last_pixel = (32'(oi_r) + 32'd1 == 32'(eff_h)) &&
                              (32'(oj_r) + 32'd1 == 32'(eff_w));
        out2_nxt.edge_magnitude = '0;
        x2_nxt = {s_r, 8'd0};
        rem2_nxt = '0; root2_nxt = '0; step2_nxt = '0;
        state2_nxt = supp_r ? egnms_pkg::ST_OUT : egnms_pkg::ST_ROOT;
      end
      egnms_pkg::ST_ROOT: begin
        if (step_r == 4'd13) begin
          // Round to nearest
          out2_nxt.edge_magnitude = (rem_r > 16'(root_r)) ? root_r + MW'(1) : root_r;
          state2_nxt = egnms_pkg::ST_OUT;
        end else begin
          x2_nxt = {x_r[XW-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem2_nxt = rem_sh - trial;
            root2_nxt = {root_r[MW-2:0], 1'b1};
          end else begin
            rem2_nxt = rem_sh;
            root2_nxt = {root_r[MW-2:0], 1'b0};
          end
          step2_nxt = step_r + 4'd1;
        end
      end
      egnms_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          use_cnt2 = 1'b1;
          if (out_r.last_pixel) begin
            row2_nxt = '0; col2_nxt = '0; rm32_nxt = '0;
          end else begin
            row2_nxt = row_adv; col2_nxt = col_adv; rm32_nxt = rm3_adv;
          end
          state2_nxt = egnms_pkg::ST_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  // Row stores
  egnms_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_pix_ram (
    .clk(clk), .we(pix_we), .waddr(pix_wa), .wdata(pix_r),
    .raddr(pix_ra), .rdata(pix_rd)
  );

  egnms_ram #(.WIDTH(SQ), .DEPTH(3 * MAX_WIDTH)) u_mag_ram (
    .clk(clk), .we(mag_we), .waddr(mag_wa), .wdata(mag_wd),
    .raddr(use_ra2 ? mag_ra2 : mag_ra), .rdata(mag_rd)
  );

  egnms_ram #(.WIDTH(3), .DEPTH(2 * MAX_WIDTH)) u_dir_ram (
    .clk(clk), .we(dir_we), .waddr(dir_wa), .wdata(dir_wd),
    .raddr(dir_ra), .rdata(dir_rd)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= egnms_pkg::ST_IDLE;
    end else begin
      state_r <= state2_nxt;
    end
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= egnms_pkg::WIDTH_RESET;
      height_r <= egnms_pkg::HEIGHT_RESET;
      row_r    <= '0;
      col_r    <= '0;
      rm3_r    <= '0;
      left_r   <= '0;
    end else begin
      left_r <= left_nxt;
      if (use_cnt2) begin
        row_r <= row2_nxt; col_r <= col2_nxt; rm3_r <= rm32_nxt;
      end else begin
        row_r <= row_nxt; col_r <= col_nxt; rm3_r <= rm3_nxt;
      end
      if (cfg_we) begin
        if (cfg_idx == egnms_pkg::REG_IMAGE_WIDTH) width_r <= cfg_wdata;
        if (cfg_idx == egnms_pkg::REG_IMAGE_HEIGHT) height_r <= cfg_wdata;
        if (cfg_idx == egnms_pkg::REG_IMAGE_WIDTH ||
            cfg_idx == egnms_pkg::REG_IMAGE_HEIGHT) begin
          row_r <= '0; col_r <= '0; rm3_r <= '0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pix_r     <= pix_nxt;
    oi_r      <= oi_nxt;
    oj_r      <= oj_nxt;
    crow_m3_r <= crow_m3_nxt;
    s_r       <= s2_nxt;
    d_r       <= d2_nxt;
    supp_r    <= supp2_nxt;
    n2a_r     <= n2a2_nxt;
    x_r       <= x2_nxt;
    rem_r     <= rem2_nxt;
    root_r    <= root2_nxt;
    step_r    <= step2_nxt;
    out_r     <= out2_nxt;
  end

  assign out_data = out_r;

  // Checks
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request taken while result pending");
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.edge_magnitude <= 13'd5793) else $error("magnitude out of range");
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last_pixel && !cfg_we) |=>
      (row_r == '0 && col_r == '0)) else $error("position not cleared after last pixel");

endmodule
